@@ hw/rtl/tbop_pkg.sv @@
// ----------------------------------------------------------------------------
// tbop_pkg
// Shared types and constants for the one-shot / periodic timer bank.
// ----------------------------------------------------------------------------
package tbop_pkg;

   localparam int NUM_TIMERS = 8;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int TIME_W     = 32;
   localparam int MASK_W     = 8;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

   // write request into the base / period store
   typedef struct packed {
      logic              base_we;
      logic              period_we;
      logic [IDX_W-1:0]  addr;
      logic [TIME_W-1:0] base_data;
      logic [TIME_W-1:0] period_data;
   } store_wr_type;

endpackage

@@ hw/rtl/timer_bank_oneshot_periodic_unit.sv @@
// ----------------------------------------------------------------------------
// timer_bank_oneshot_periodic_unit
// Bank of software timers with tick, start, stop and query commands.
// ----------------------------------------------------------------------------
// One request beat is taken at a time. Start, stop and query go from accept
// straight to ST_RESP; a tick first passes through ST_SWEEP, which reads one
// timer per cycle from the single read port of the base/period memory and
// checks it in the one shared expiry comparator. The result register lets
// the next request be accepted while a result waits. Base and period
// memories need no clearing: a timer that was never started is ignored.
// ----------------------------------------------------------------------------
module timer_bank_oneshot_periodic_unit
   import tbop_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] command
   input  logic [1:0]  req_tuser,
   // [2:0] timer_index, [34:3] period_ticks, [35] repeat_req
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] running, [1] expired, [9:2] expired_mask
   output logic [15:0] rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] tick_ff, tick_in;
   logic [NUM_TIMERS-1:0] running_ff, running_in;
   logic [NUM_TIMERS-1:0] repeat_ff, repeat_in;
   logic [NUM_TIMERS-1:0] expired_ff, expired_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic              slot_ok_ff, slot_ok_in;
   logic [CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic              eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]  eval_idx_ff, eval_idx_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]       rsp_tdata_ff, rsp_tdata_in;

   cmd_type           req_cmd;
   logic [2:0]        req_index;
   logic [TIME_W-1:0] req_period;
   logic              req_repeat;
   logic [IDX_W-1:0]  req_slot;
   logic              req_ok;
   logic              req_fire;

   store_wr_type      store_wr;
   logic [IDX_W-1:0]  rd_addr;
   logic [TIME_W-1:0] rd_base;
   logic [TIME_W-1:0] rd_period;
   logic              due;
   logic [MASK_W-1:0] mask;

   assign req_cmd    = cmd_type'(req_tuser);
   assign req_index  = req_tdata[2:0];
   assign req_period = req_tdata[34:3];
   assign req_repeat = req_tdata[35];
   assign req_slot   = IDX_W'(req_index);
   assign req_ok     = (7'(req_index) < 7'(NUM_TIMERS));
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   tbop_store u_store (
      .clock     (clock),
      .wr        (store_wr),
      .rd_addr   (rd_addr),
      .rd_base   (rd_base),
      .rd_period (rd_period)
   );

   tbop_due u_due (
      .now    (tick_ff),
      .base   (rd_base),
      .period (rd_period),
      .due    (due)
   );

   always_comb begin
      mask = '0;
      for (int t = 0; t < MASK_W; t++) begin
         if (t < NUM_TIMERS) begin
            mask[t] = expired_ff[t];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      tick_in       = tick_ff;
      running_in    = running_ff;
      repeat_in     = repeat_ff;
      expired_in    = expired_ff;
      slot_in       = slot_ff;
      slot_ok_in    = slot_ok_ff;
      rd_cnt_in     = rd_cnt_ff;
      eval_vld_in   = 1'b0;
      eval_idx_in   = eval_idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      store_wr      = '0;
      rd_addr       = rd_cnt_ff[IDX_W-1:0];

      // finish check of the timer whose memory read came back this cycle
      if (eval_vld_ff) begin
         if (!running_ff[eval_idx_ff] || !due) begin
            expired_in[eval_idx_ff] = 1'b0;
         end else begin
            expired_in[eval_idx_ff] = 1'b1;
            if (repeat_ff[eval_idx_ff]) begin
               store_wr.base_we   = 1'b1;
               store_wr.addr      = eval_idx_ff;
               store_wr.base_data = tick_ff;
            end else begin
               running_in[eval_idx_ff] = 1'b0;
            end
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               slot_in    = req_slot;
               slot_ok_in = req_ok;
               state_in   = ST_RESP;
               unique case (req_cmd)
                  CMD_TICK: begin
                     tick_in   = tick_ff + 1'b1;
                     rd_cnt_in = '0;
                     state_in  = ST_SWEEP;
                  end
                  CMD_START: begin
                     if (req_ok) begin
                        store_wr.base_we     = 1'b1;
                        store_wr.period_we   = 1'b1;
                        store_wr.addr        = req_slot;
                        store_wr.base_data   = tick_ff;
                        store_wr.period_data = req_period;
                        running_in[req_slot] = 1'b1;
                        repeat_in[req_slot]  = req_repeat;
                        expired_in[req_slot] = (req_period == '0);
                     end
                  end
                  CMD_STOP: begin
                     if (req_ok) begin
                        running_in[req_slot] = 1'b0;
                        expired_in[req_slot] = 1'b0;
                     end
                  end
                  CMD_QUERY: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            // issue one read per cycle; the check follows in the next cycle
            if (rd_cnt_ff < CNT_W'(NUM_TIMERS)) begin
               eval_vld_in = 1'b1;
               eval_idx_in = rd_cnt_ff[IDX_W-1:0];
               rd_cnt_in   = rd_cnt_ff + 1'b1;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {6'b0, mask,
                                slot_ok_ff && expired_ff[slot_ff],
                                slot_ok_ff && running_ff[slot_ff]};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tick_ff       <= '0;
         running_ff    <= '0;
         repeat_ff     <= '0;
         expired_ff    <= '0;
         rd_cnt_ff     <= '0;
         eval_vld_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         running_ff    <= running_in;
         repeat_ff     <= repeat_in;
         expired_ff    <= expired_in;
         rd_cnt_ff     <= rd_cnt_in;
         eval_vld_ff   <= eval_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      slot_ff      <= slot_in;
      slot_ok_ff   <= slot_ok_in;
      eval_idx_ff  <= eval_idx_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_cmd == CMD_TICK) |=> tick_ff == $past(tick_ff) + 1'b1)
      else $error("tick count did not advance on tick beat");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= CNT_W'(NUM_TIMERS))
      else $error("sweep counter ran past the bank");

   a_eval_in_sweep: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (state_ff == ST_SWEEP) || (state_ff == ST_RESP))
      else $error("timer check outside of a sweep");

   a_flags_hold_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && !req_fire |=> $stable(running_ff) && $stable(expired_ff))
      else $error("timer flags changed while idle");
`endif

endmodule

@@ hw/rtl/tbop_store.sv @@
// ----------------------------------------------------------------------------
// tbop_store
// Base time and period memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tbop_store
   import tbop_pkg::*;
(
   input  logic              clock,
   input  store_wr_type      wr,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [TIME_W-1:0] rd_base,
   output logic [TIME_W-1:0] rd_period
);

   logic [TIME_W-1:0] base_mem   [NUM_TIMERS];
   logic [TIME_W-1:0] period_mem [NUM_TIMERS];
   logic [TIME_W-1:0] rd_base_ff;
   logic [TIME_W-1:0] rd_period_ff;

   always_ff @(posedge clock) begin
      if (wr.base_we) begin
         base_mem[wr.addr] <= wr.base_data;
      end
      if (wr.period_we) begin
         period_mem[wr.addr] <= wr.period_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_base_ff   <= base_mem[rd_addr];
      rd_period_ff <= period_mem[rd_addr];
   end

   assign rd_base   = rd_base_ff;
   assign rd_period = rd_period_ff;

endmodule

@@ hw/rtl/tbop_due.sv @@
// ----------------------------------------------------------------------------
// tbop_due
// Shared expiry compare: elapsed time with wrapping subtract against period.
// ----------------------------------------------------------------------------
module tbop_due
   import tbop_pkg::*;
(
   input  logic [TIME_W-1:0] now,
   input  logic [TIME_W-1:0] base,
   input  logic [TIME_W-1:0] period,
   output logic              due
);

   logic [TIME_W-1:0] elapsed;

   assign elapsed = now - base;
   assign due     = (elapsed >= period);

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the one-shot / periodic timer bank.
// Sends tick, start, stop and query beats through the request stream. It keeps
// its own copy of the timer bank to compute the expected flags. Every response
// beat is compared field by field, with random idling on both streams and one
// long response hold-off.
// ----------------------------------------------------------------------------
module tb;
   import tbop_pkg::*;

   localparam int CLOCK_HALF       = 2;
   localparam int RESET_CYCLES     = 5;
   localparam int RANDOM_ITEMS     = 1500;
   localparam int BURST_ITEMS      = 60;
   localparam int STREAK_ITEMS     = 80;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 40;
   localparam int CYCLE_LIMIT      = 1000000;

   typedef struct packed {
      logic              running;
      logic              expired;
      logic [MASK_W-1:0] mask;
   } flag_report_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   // shadow of the timer bank
   logic [TIME_W-1:0]     tick_now = '0;
   logic [TIME_W-1:0]     base_mem   [NUM_TIMERS];
   logic [TIME_W-1:0]     period_mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] run_bits     = '0;
   logic [NUM_TIMERS-1:0] repeat_bits  = '0;
   logic [NUM_TIMERS-1:0] expired_bits = '0;

   flag_report_type flag_report_q[$];
   flag_report_type want_flags;
   int           error_count   = 0;
   int           cycle_count   = 0;
   int           stall_left    = 0;
   logic         idle_enable   = 1'b1;
   logic         long_hold_armed = 1'b0;
   logic         long_hold_done  = 1'b0;

   timer_bank_oneshot_periodic_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int short_or_long_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // Compute the flags after one command and advance the shadow bank.
   function automatic flag_report_type apply_timer_cmd(input cmd_type cmd,
         input logic [IDX_W-1:0] idx, input logic [TIME_W-1:0] period, input logic rep);
      flag_report_type   rpt;
      logic [TIME_W-1:0] elapsed;
      logic              in_bank;
      in_bank = (int'(idx) < NUM_TIMERS);
      case (cmd)
         CMD_TICK: begin
            tick_now = tick_now + 1'b1;
            for (int t = 0; t < NUM_TIMERS; t++) begin
               elapsed = tick_now - base_mem[t];
               if (!run_bits[t]) begin
                  expired_bits[t] = 1'b0;
               end else if (elapsed >= period_mem[t]) begin
                  expired_bits[t] = 1'b1;
                  if (repeat_bits[t]) begin
                     base_mem[t] = tick_now;
                  end else begin
                     run_bits[t] = 1'b0;
                  end
               end else begin
                  expired_bits[t] = 1'b0;
               end
            end
         end
         CMD_START: begin
            if (in_bank) begin
               base_mem[idx]     = tick_now;
               period_mem[idx]   = period;
               run_bits[idx]     = 1'b1;
               repeat_bits[idx]  = rep;
               expired_bits[idx] = (period == '0);
            end
         end
         CMD_STOP: begin
            if (in_bank) begin
               run_bits[idx]     = 1'b0;
               expired_bits[idx] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      rpt.running = in_bank && run_bits[idx];
      rpt.expired = in_bank && expired_bits[idx];
      rpt.mask    = '0;
      for (int t = 0; t < NUM_TIMERS && t < MASK_W; t++) begin
         rpt.mask[t] = expired_bits[t];
      end
      return rpt;
   endfunction

   // Offer one beat, hold it until taken, then, when idling is enabled, sometimes idle for a random gap.
   task automatic send_cmd(input cmd_type cmd, input logic [IDX_W-1:0] idx,
         input logic [TIME_W-1:0] period, input logic rep);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, rep, period, idx};
      do @(posedge clock); while (!req_tready);
      flag_report_q.push_back(apply_timer_cmd(cmd, idx, period, rep));
      gap = 0;
      if (idle_enable && $urandom_range(0, 99) >= 55) begin
         gap = short_or_long_gap();
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_cmd();
      int                r;
      cmd_type           cmd;
      logic [TIME_W-1:0] period;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         cmd = CMD_TICK;
      end else if (r < 65) begin
         cmd = CMD_START;
      end else if (r < 75) begin
         cmd = CMD_STOP;
      end else begin
         cmd = CMD_QUERY;
      end
      period = $urandom;
      if (cmd == CMD_START) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            period = $urandom_range(0, 12);
         end else if (r < 85) begin
            period = $urandom_range(13, 60);
         end else if (r < 97) begin
            case ($urandom_range(0, 2))
               0:       period = 32'hFFFF_FFFF;
               1:       period = 32'h8000_0000;
               default: period = 32'h7FFF_FFFF;
            endcase
         end
      end
      send_cmd(cmd, IDX_W'($urandom_range(0, NUM_TIMERS - 1)), period, 1'($urandom));
   endtask

   task automatic test_directed_cases();
      send_cmd(CMD_QUERY, 0, 32'h0, 1'b0);
      send_cmd(CMD_START, 0, 32'h0, 1'b0);           // zero period, one-shot
      send_cmd(CMD_START, 1, 32'h1, 1'b1);
      send_cmd(CMD_START, 2, 32'h3, 1'b0);
      send_cmd(CMD_START, 7, 32'hFFFF_FFFF, 1'b1);   // never due
      send_cmd(CMD_START, 3, 32'h0, 1'b1);           // zero period, periodic
      send_cmd(CMD_TICK, 0, 32'hFFFF_FFFF, 1'b1);
      send_cmd(CMD_TICK, 1, 32'h0, 1'b0);
      send_cmd(CMD_TICK, 2, 32'h0, 1'b0);
      send_cmd(CMD_QUERY, 2, 32'h0, 1'b0);
      send_cmd(CMD_STOP, 1, 32'h0, 1'b0);
      send_cmd(CMD_STOP, 2, 32'h0, 1'b0);            // already stopped
      send_cmd(CMD_STOP, 5, 32'h0, 1'b0);            // never started
      send_cmd(CMD_QUERY, 7, 32'hFFFF_FFFF, 1'b1);
      send_cmd(CMD_START, 4, 32'h8000_0000, 1'b0);
      send_cmd(CMD_START, 5, 32'h2, 1'b1);
      send_cmd(CMD_TICK, 5, 32'h0, 1'b0);
      send_cmd(CMD_TICK, 5, 32'h0, 1'b0);
      send_cmd(CMD_QUERY, 3, 32'h0, 1'b0);
      send_cmd(CMD_STOP, 3, 32'h0, 1'b0);
      send_cmd(CMD_START, 6, 32'h7FFF_FFFF, 1'b1);
      send_cmd(CMD_TICK, 6, 32'h0, 1'b0);
      send_cmd(CMD_QUERY, 5, 32'h0, 1'b0);
   endtask

   task automatic test_random_traffic();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_random_cmd();
      end
   endtask

   // Hold the response stream off while requests keep coming back to back.
   task automatic test_output_backpressure();
      idle_enable     <= 1'b0;
      long_hold_armed <= 1'b1;
      for (int i = 0; i < BURST_ITEMS; i++) begin
         send_random_cmd();
      end
   endtask

   task automatic test_back_to_back();
      idle_enable <= 1'b0;
      for (int i = 0; i < STREAK_ITEMS; i++) begin
         send_random_cmd();
      end
      idle_enable <= 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (long_hold_armed && !long_hold_done) begin
            stall_left     = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else if (stall_left == 0 && idle_enable && $urandom_range(0, 99) < 20) begin
            stall_left = short_or_long_gap();
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left = stall_left - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (flag_report_q.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want_flags = flag_report_q.pop_front();
            if (rsp_tdata[0] !== want_flags.running) begin
               $display("%0t: running mismatch, expected %0b actual %0b",
                        $time, want_flags.running, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[1] !== want_flags.expired) begin
               $display("%0t: expired mismatch, expected %0b actual %0b",
                        $time, want_flags.expired, rsp_tdata[1]);
               error_count++;
            end
            if (rsp_tdata[9:2] !== want_flags.mask) begin
               $display("%0t: expired_mask mismatch, expected %02h actual %02h",
                        $time, want_flags.mask, rsp_tdata[9:2]);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic();
      test_output_backpressure();
      test_back_to_back();
      req_tvalid <= 1'b0;
      while (flag_report_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ timer_bank_oneshot_periodic_unit.f @@
hw/rtl/tbop_pkg.sv
hw/rtl/tbop_store.sv
hw/rtl/tbop_due.sv
hw/rtl/timer_bank_oneshot_periodic_unit.sv
tb/sv/tb.sv
